// File: rtl/core/scfl_pkg.sv
`timescale 1ns / 1ps

package scfl_pkg;

	// fixed field widths
	localparam int ADDR_W      = 48;
	localparam int SIZE_W      = 32;
	localparam int CSIZE_W     = 16;
	localparam int HCLASS_W    = 3;
	localparam int CLASS_OUT_W = 4;
	localparam int KIND_W      = 2;
	localparam int THR_W       = 7;
	localparam int MIN_W       = 16;
	localparam int CFG_W       = 64;
	localparam int PADDR_W     = 5;

	// flush limit
	localparam int MAX_RESULTS = 32;
	localparam int FLUSH_W     = 6;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CACHED      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BACKEND_REQ = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE     = 2'd2;

	localparam logic [CLASS_OUT_W-1:0] NO_CLASS = 4'd8;

	// register indexes
	localparam logic [1:0] REG_SIZES_LOW  = 2'd0;
	localparam logic [1:0] REG_SIZES_HIGH = 2'd1;
	localparam logic [1:0] REG_MIN_REQ    = 2'd2;
	localparam logic [1:0] REG_FLUSH_THR  = 2'd3;

	localparam logic [MIN_W-1:0] MIN_REQ_RESET   = 16'd16;
	localparam logic [THR_W-1:0] FLUSH_THR_RESET = 7'd64;

	typedef struct packed {
		logic [CFG_W-1:0] class_sizes_low;
		logic [CFG_W-1:0] class_sizes_high;
		logic [MIN_W-1:0] minimum_request;
		logic [THR_W-1:0] flush_threshold;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic pop;
		logic emit_single;
		logic emit_pop;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic single;
		logic flush;
		logic slot_free;
		logic pop_done;
	} status_t;

endpackage

// File: rtl/core/scfl_item_if.sv
`timescale 1ns / 1ps

interface scfl_item_if;
	import scfl_pkg::*;

	logic                valid;
	logic                ready;
	logic                operation;
	logic [SIZE_W-1:0]   request_size;
	logic [ADDR_W-1:0]   block_address;
	logic                header_valid;
	logic [HCLASS_W-1:0] header_class;

	modport source (
		output valid, operation, request_size, block_address, header_valid, header_class,
		input  ready
	);

	modport sink (
		input  valid, operation, request_size, block_address, header_valid, header_class,
		output ready
	);

endinterface

// File: rtl/core/scfl_result_if.sv
`timescale 1ns / 1ps

interface scfl_result_if;
	import scfl_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [KIND_W-1:0]      result_kind;
	logic [ADDR_W-1:0]      address_out;
	logic [CLASS_OUT_W-1:0] class_out;
	logic [SIZE_W-1:0]      size_out;
	logic                   last;

	modport source (
		output valid, result_kind, address_out, class_out, size_out, last,
		input  ready
	);

	modport sink (
		input  valid, result_kind, address_out, class_out, size_out, last,
		output ready
	);

endinterface

// File: rtl/core/scfl_regs.sv
`timescale 1ns / 1ps

module scfl_regs
	import scfl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]   pwdata,
	output logic [CFG_W-1:0]   prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[PADDR_W-1:3];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.class_sizes_low  <= '0;
			cfg_q.class_sizes_high <= '0;
			cfg_q.minimum_request  <= MIN_REQ_RESET;
			cfg_q.flush_threshold  <= FLUSH_THR_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_SIZES_LOW:  cfg_q.class_sizes_low  <= pwdata;
				REG_SIZES_HIGH: cfg_q.class_sizes_high <= pwdata;
				REG_MIN_REQ:    cfg_q.minimum_request  <= pwdata[MIN_W-1:0];
				REG_FLUSH_THR:  cfg_q.flush_threshold  <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_SIZES_LOW:  prdata = cfg_q.class_sizes_low;
			REG_SIZES_HIGH: prdata = cfg_q.class_sizes_high;
			REG_MIN_REQ:    prdata = CFG_W'(cfg_q.minimum_request);
			REG_FLUSH_THR:  prdata = CFG_W'(cfg_q.flush_threshold);
			default:        prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/scfl_ctrl.sv
`timescale 1ns / 1ps

module scfl_ctrl
	import scfl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EMIT,
		S_POP,
		S_POP_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	// commands from current state
	always_comb begin
		cmd             = '0;
		cmd.start       = (state_q == S_IDLE) && in_valid;
		cmd.pop         = (state_q == S_POP);
		cmd.emit_single = (state_q == S_EMIT) && status.slot_free;
		cmd.emit_pop    = (state_q == S_POP_EMIT) && status.slot_free;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (status.single)
							state_q <= S_EMIT;
						else if (status.flush)
							state_q <= S_POP;
					end
				end
				S_EMIT: begin
					if (status.slot_free)
						state_q <= S_IDLE;
				end
				S_POP: begin
					state_q <= S_POP_EMIT;
				end
				S_POP_EMIT: begin
					if (status.slot_free)
						state_q <= status.pop_done ? S_IDLE : S_POP;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/scfl_datapath.sv
`timescale 1ns / 1ps

module scfl_datapath
	import scfl_pkg::*;
#(
	parameter int CLASS_COUNT  = 8,
	parameter int STACK_DEPTH  = 64,
	parameter int ADDRESS_BITS = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic                   operation,
	input  logic [SIZE_W-1:0]      request_size,
	input  logic [ADDR_W-1:0]      block_address,
	input  logic                   header_valid,
	input  logic [HCLASS_W-1:0]    header_class,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [KIND_W-1:0]      result_kind,
	output logic [ADDR_W-1:0]      address_out,
	output logic [CLASS_OUT_W-1:0] class_out,
	output logic [SIZE_W-1:0]      size_out,
	output logic                   last
);

	localparam int AW    = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam int DEPTH = CLASS_COUNT * STACK_DEPTH;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int CI_W  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
	localparam int HW    = (CNT_W > FLUSH_W) ? CNT_W : FLUSH_W;

	function automatic logic [CSIZE_W-1:0] class_size(cfg_t c, logic [HCLASS_W-1:0] k);
		logic [CFG_W-1:0] word;
		word = k[2] ? c.class_sizes_high : c.class_sizes_low;
		return word[k[1:0]*CSIZE_W +: CSIZE_W];
	endfunction

	// stack memory and counts
	logic [AW-1:0]    mem [DEPTH];
	logic [AW-1:0]    rd_q;
	logic [CNT_W-1:0] cnt_q [CLASS_COUNT];

	// per-item state
	logic [HCLASS_W-1:0]    cls_q;
	logic [FLUSH_W-1:0]     remaining_q;
	logic                   hit_q;
	logic [KIND_W-1:0]      kind_q;
	logic [CLASS_OUT_W-1:0] cls_out_q;
	logic [SIZE_W-1:0]      size_q;
	logic [AW-1:0]          addr_q;
	logic                   out_valid_q;

	logic                is_free;
	logic [SIZE_W-1:0]   raised;
	logic                fit;
	logic [HCLASS_W-1:0] sel;
	logic                hdr_ok;
	logic                push;
	logic                hit;
	logic [CI_W-1:0]     cidx;
	logic [CNT_W-1:0]    cnt_rd;
	logic [CNT_W-1:0]    newcnt;
	logic [CMP_W-1:0]    thr;
	logic [HW-1:0]       half_ext;
	logic [FLUSH_W-1:0]  half_n;
	logic [HCLASS_W-1:0] mem_cls;
	logic [CNT_W-1:0]    top;
	logic [IDX_W-1:0]    mem_idx;
	logic                mem_we;
	logic                mem_re;
	logic                slot_free;

	assign is_free = (operation == OP_FREE);

	// raise to minimum and search the class table
	always_comb begin
		raised = (request_size < SIZE_W'(cfg.minimum_request))
			? SIZE_W'(cfg.minimum_request) : request_size;
		fit = 1'b0;
		sel = '0;
		for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
			if (SIZE_W'(class_size(cfg, HCLASS_W'(c))) >= raised) begin
				fit = 1'b1;
				sel = HCLASS_W'(c);
			end
		end
	end

	assign hdr_ok = header_valid && ({1'b0, header_class} < CLASS_OUT_W'(CLASS_COUNT));
	assign push   = is_free && hdr_ok;

	// single count read port
	always_comb begin
		if (cmd.pop)
			cidx = cls_q[CI_W-1:0];
		else if (is_free)
			cidx = header_class[CI_W-1:0];
		else
			cidx = sel[CI_W-1:0];
	end

	assign cnt_rd = cnt_q[cidx];
	assign hit    = fit && (cnt_rd != '0);
	assign newcnt = cnt_rd + CNT_W'(1);

	// flush size after a push
	always_comb begin
		thr = (CMP_W'(cfg.flush_threshold) > CMP_W'(STACK_DEPTH))
			? CMP_W'(STACK_DEPTH) : CMP_W'(cfg.flush_threshold);
		half_ext = HW'(newcnt >> 1);
		if (CMP_W'(newcnt) < thr)
			half_n = '0;
		else if (half_ext > HW'(MAX_RESULTS))
			half_n = FLUSH_W'(MAX_RESULTS);
		else
			half_n = FLUSH_W'(half_ext);
	end

	// stack memory address
	always_comb begin
		if (cmd.pop)
			mem_cls = cls_q;
		else if (is_free)
			mem_cls = header_class;
		else
			mem_cls = sel;
		top     = (cmd.pop || !is_free) ? (cnt_rd - CNT_W'(1)) : cnt_rd;
		mem_idx = IDX_W'(mem_cls) * IDX_W'(STACK_DEPTH) + IDX_W'(top);
	end

	assign mem_we = cmd.start && push;
	assign mem_re = (cmd.start && !is_free && hit) || cmd.pop;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_idx] <= block_address[AW-1:0];
		if (mem_re)
			rd_q <= mem[mem_idx];
	end

	// stack counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_COUNT; i++)
				cnt_q[i] <= '0;
		end else if (cmd.start && !is_free && hit) begin
			cnt_q[cidx] <= cnt_rd - CNT_W'(1);
		end else if (cmd.start && push) begin
			cnt_q[cidx] <= newcnt;
		end else if (cmd.pop) begin
			cnt_q[cidx] <= cnt_rd - CNT_W'(1);
		end
	end

	// flush counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			remaining_q <= '0;
		else if (cmd.start)
			remaining_q <= push ? half_n : '0;
		else if (cmd.pop)
			remaining_q <= remaining_q - FLUSH_W'(1);
	end

	// result fields of the accepted item
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cls_q <= push ? header_class : sel;
			if (!is_free) begin
				hit_q     <= hit;
				kind_q    <= hit ? KIND_CACHED : KIND_BACKEND_REQ;
				cls_out_q <= fit ? {1'b0, sel} : NO_CLASS;
				addr_q    <= '0;
				if (hit)
					size_q <= '0;
				else if (fit)
					size_q <= SIZE_W'(class_size(cfg, sel));
				else
					size_q <= raised;
			end else begin
				hit_q     <= 1'b0;
				kind_q    <= KIND_RELEASE;
				cls_out_q <= NO_CLASS;
				addr_q    <= block_address[AW-1:0];
				size_q    <= '0;
			end
		end
	end

	// output register
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_single || cmd.emit_pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_single) begin
			result_kind <= kind_q;
			address_out <= hit_q ? ADDR_W'(rd_q) : ADDR_W'(addr_q);
			class_out   <= cls_out_q;
			size_out    <= size_q;
			last        <= 1'b1;
		end else if (cmd.emit_pop) begin
			result_kind <= KIND_RELEASE;
			address_out <= ADDR_W'(rd_q);
			class_out   <= {1'b0, cls_q};
			size_out    <= '0;
			last        <= (remaining_q == '0);
		end
	end

	assign out_valid = out_valid_q;

	// status back to the controller
	always_comb begin
		status           = '0;
		status.single    = !is_free || !hdr_ok;
		status.flush     = push && (half_n != '0);
		status.slot_free = slot_free;
		status.pop_done  = (remaining_q == '0);
	end

	// a pop never hits an empty stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (cnt_rd != '0))
		else $error("pop from empty stack");

	// a push never overflows the stack
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (cnt_rd < CNT_W'(STACK_DEPTH)))
		else $error("push into full stack");

	// results load only into a free output slot
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_single || cmd.emit_pop) |-> slot_free)
		else $error("result overwrites pending transfer");

	// a pop only runs while releases remain
	a_pop_budget: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (remaining_q != '0))
		else $error("pop past flush length");

endmodule

// File: rtl/core/size_class_free_list_cache.sv
`timescale 1ns / 1ps

// Size-class free-list cache: one LIFO stack of free block addresses per class.
// Input channel item carries allocate or free items, output channel result
// carries result transfers; last marks the final result of an item.
// Registers sit behind the APB port at byte addresses 0, 8, 16, 24.
// Allocate item: one result; on accept the stack memory read or request is
// registered, then loaded into the output register.
// Free with passing header check and no flush: no result.
// Free with failed header check: one release result.
// Flush of n entries: each release takes one stack memory read step and one
// output load step.
// Only one item is in work at a time; a new item is taken once the previous
// one has loaded its last result, even while that result waits in the output
// register. A stalled receiver holds the block in its load step.
// Reset clears all stack counts and restores register defaults; no clearing
// pass runs, so the block accepts items right after reset.
module size_class_free_list_cache
	import scfl_pkg::*;
#(
	parameter int CLASS_COUNT  = 8,
	parameter int STACK_DEPTH  = 64,
	parameter int ADDRESS_BITS = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	scfl_item_if.sink          item,
	scfl_result_if.source      result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]   pwdata,
	output logic [CFG_W-1:0]   prdata,
	output logic               pready
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	assign item.ready = in_ready;

	// configuration registers
	scfl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	scfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// stacks, counts and output register
	scfl_datapath #(
		.CLASS_COUNT  (CLASS_COUNT),
		.STACK_DEPTH  (STACK_DEPTH),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.status        (status),
		.operation     (item.operation),
		.request_size  (item.request_size),
		.block_address (item.block_address),
		.header_valid  (item.header_valid),
		.header_class  (item.header_class),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.result_kind   (result.result_kind),
		.address_out   (result.address_out),
		.class_out     (result.class_out),
		.size_out      (result.size_out),
		.last          (result.last)
	);

endmodule

// File: tb/size_class_free_list_cache_tb.sv
`timescale 1ns / 1ps

module size_class_free_list_cache_tb;
	import scfl_pkg::*;

	localparam int CLASSES       = 8;
	localparam int DEPTH         = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;

	// power-of-two class table used by several phases
	localparam logic [CFG_W-1:0] TABLE_A_LOW  = {16'd128, 16'd64, 16'd32, 16'd16};
	localparam logic [CFG_W-1:0] TABLE_A_HIGH = {16'd2048, 16'd1024, 16'd512, 16'd256};

	typedef struct packed {
		logic                operation;
		logic [SIZE_W-1:0]   request_size;
		logic [ADDR_W-1:0]   block_address;
		logic                header_valid;
		logic [HCLASS_W-1:0] header_class;
	} cache_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [ADDR_W-1:0]      address;
		logic [CLASS_OUT_W-1:0] size_cls;
		logic [SIZE_W-1:0]      bytes;
		logic                   last;
	} cache_result_t;

	// per-class free stacks, register copies and the results still owed
	class free_list_scoreboard;
		logic [CSIZE_W-1:0] class_size [CLASSES];
		logic [MIN_W-1:0]   min_request;
		logic [THR_W-1:0]   threshold;
		logic [ADDR_W-1:0]  stacks [CLASSES][DEPTH];
		int unsigned        depth [CLASSES];
		cache_result_t      expected [$];
		int unsigned        mismatches;

		function new();
			min_request = MIN_REQ_RESET;
			threshold   = FLUSH_THR_RESET;
			mismatches  = 0;
			foreach (class_size[c]) begin
				class_size[c] = '0;
				depth[c]      = 0;
			end
		endfunction

		function void set_register(logic [1:0] index, logic [CFG_W-1:0] value);
			case (index)
				REG_SIZES_LOW: begin
					for (int c = 0; c < 4; c++) class_size[c] = value[16*c +: 16];
				end
				REG_SIZES_HIGH: begin
					for (int c = 0; c < 4; c++) class_size[c+4] = value[16*c +: 16];
				end
				REG_MIN_REQ:   min_request = value[MIN_W-1:0];
				REG_FLUSH_THR: threshold   = value[THR_W-1:0];
				default: ;
			endcase
		endfunction

		function void add_result(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] address,
				logic [CLASS_OUT_W-1:0] size_cls, logic [SIZE_W-1:0] bytes);
			expected.push_back({kind, address, size_cls, bytes, 1'b0});
		endfunction

		// work out the results one accepted item causes
		function void note_item(cache_item_t it);
			logic [SIZE_W-1:0] want;
			int                c;
			int                hit;
			int unsigned       thr;
			int unsigned       half;
			int unsigned       owed_before;
			owed_before = expected.size();
			if (it.operation == OP_ALLOC) begin
				want = it.request_size;
				if (want < SIZE_W'(min_request)) want = SIZE_W'(min_request);
				hit = CLASSES;
				for (c = CLASSES - 1; c >= 0; c--)
					if (SIZE_W'(class_size[c]) >= want) hit = c;
				if (hit == CLASSES) begin
					add_result(KIND_BACKEND_REQ, '0, NO_CLASS, want);
				end else if (depth[hit] > 0) begin
					depth[hit]--;
					add_result(KIND_CACHED, stacks[hit][depth[hit]], CLASS_OUT_W'(hit), '0);
				end else begin
					add_result(KIND_BACKEND_REQ, '0, CLASS_OUT_W'(hit),
						SIZE_W'(class_size[hit]));
				end
			end else if (!it.header_valid) begin
				add_result(KIND_RELEASE, it.block_address, NO_CLASS, '0);
			end else begin
				c = int'(it.header_class);
				stacks[c][depth[c]] = it.block_address;
				depth[c]++;
				thr = (threshold > DEPTH) ? DEPTH : threshold;
				// flush half the stack, newest first
				if (depth[c] >= thr) begin
					half = depth[c] / 2;
					if (half > MAX_RESULTS) half = MAX_RESULTS;
					repeat (half) begin
						depth[c]--;
						add_result(KIND_RELEASE, stacks[c][depth[c]], CLASS_OUT_W'(c), '0);
					end
				end
			end
			if (expected.size() > owed_before) expected[$].last = 1'b1;
		endfunction

		function void check_result(cache_result_t got);
			cache_result_t want;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d addr %h class %0d size %h last %0b",
						got.kind, got.address, got.size_cls, got.bytes, got.last);
			end else begin
				want = expected.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch: expected kind %0d addr %h class %0d size %h last %0b",
							want.kind, want.address, want.size_cls, want.bytes, want.last);
						$display("                 got kind %0d addr %h class %0d size %h last %0b",
							got.kind, got.address, got.size_cls, got.bytes, got.last);
					end
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [CFG_W-1:0]   pwdata;
	logic [CFG_W-1:0]   prdata;
	logic               pready;

	scfl_item_if   item_bus ();
	scfl_result_if result_bus ();

	free_list_scoreboard board;
	bit                  item_calm;
	bit                  result_calm;
	int                  stalled_cycles = 0;

	size_class_free_list_cache u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// wait before the next transfer, with runs of back-to-back traffic
	function automatic int draw_gap(ref bit calm);
		if ($urandom_range(0, 24) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic cache_item_t alloc_item(logic [SIZE_W-1:0] bytes);
		cache_item_t it;
		it               = '0;
		it.operation     = OP_ALLOC;
		it.request_size  = bytes;
		return it;
	endfunction

	function automatic cache_item_t free_item(logic valid, logic [HCLASS_W-1:0] size_cls,
			logic [ADDR_W-1:0] address);
		cache_item_t it;
		it               = '0;
		it.operation     = OP_FREE;
		it.header_valid  = valid;
		it.header_class  = size_cls;
		it.block_address = address;
		return it;
	endfunction

	// mostly traffic on one hot class, allocs sized to land on a known class
	function automatic cache_item_t make_item(int hot, int free_weight);
		cache_item_t it;
		int          pick;
		it.block_address = ADDR_W'({$urandom, $urandom});
		it.request_size  = $urandom;
		it.header_class  = HCLASS_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : hot);
		it.header_valid  = 1'b1;
		pick = $urandom_range(0, 99);
		if (pick < free_weight) begin
			it.operation = OP_FREE;
		end else if (pick < free_weight + 8) begin
			it.operation    = OP_FREE;
			it.header_valid = 1'b0;
		end else begin
			it.operation = OP_ALLOC;
			if ($urandom_range(0, 9) != 0)
				it.request_size = $urandom_range(0, board.class_size[it.header_class]);
		end
		return it;
	endfunction

	function automatic void ascending_table(output logic [CFG_W-1:0] lo,
			output logic [CFG_W-1:0] hi);
		int unsigned sizes [$];
		repeat (CLASSES) sizes.push_back($urandom_range(0, 16'hFFFF));
		sizes.sort();
		for (int i = 0; i < 4; i++) begin
			lo[16*i +: 16] = CSIZE_W'(sizes[i]);
			hi[16*i +: 16] = CSIZE_W'(sizes[i+4]);
		end
	endfunction

	task automatic send_item(input cache_item_t it);
		int gap;
		gap = draw_gap(item_calm);
		@(negedge clk);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_bus.valid         <= 1'b1;
		item_bus.operation     <= it.operation;
		item_bus.request_size  <= it.request_size;
		item_bus.block_address <= it.block_address;
		item_bus.header_valid  <= it.header_valid;
		item_bus.header_class  <= it.header_class;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		board.note_item(it);
	endtask

	// stop sending and let every owed result and any silent push finish
	task automatic settle();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (board.expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [CFG_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_register(index, value);
	endtask

	task automatic configure(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
			input logic [MIN_W-1:0] minimum, input logic [THR_W-1:0] thr);
		write_register(REG_SIZES_LOW, lo);
		write_register(REG_SIZES_HIGH, hi);
		write_register(REG_MIN_REQ, {{(CFG_W-MIN_W){1'b0}}, minimum});
		write_register(REG_FLUSH_THR, {{(CFG_W-THR_W){1'b0}}, thr});
	endtask

	// result side: stall for a drawn number of cycles before each transfer
	initial begin : result_receiver
		int hold;
		result_bus.ready = 1'b1;
		forever begin
			hold = draw_gap(result_calm);
			if (hold > 0) begin
				@(negedge clk);
				result_bus.ready <= 1'b0;
				repeat (hold) @(negedge clk);
				result_bus.ready <= 1'b1;
			end
			do @(posedge clk); while (!(result_bus.valid === 1'b1 && result_bus.ready));
		end
	end

	// check every result transfer against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready)
			board.check_result({result_bus.result_kind, result_bus.address_out,
				result_bus.class_out, result_bus.size_out, result_bus.last});
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
				(result_bus.valid === 1'b1 && result_bus.ready) || psel)
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles == STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		logic [MIN_W-1:0] minimum;
		logic [THR_W-1:0] thr;
		int               len;
		int               weight;
		int               hot;
		int               phase;
		board                  = new();
		arst_n                 = 1'b0;
		item_bus.valid         = 1'b0;
		item_bus.operation     = OP_ALLOC;
		item_bus.request_size  = '0;
		item_bus.block_address = '0;
		item_bus.header_valid  = 1'b0;
		item_bus.header_class  = '0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset table is all zero, so no class fits any request
		send_item(alloc_item(32'd0));
		send_item(alloc_item(32'hFFFF_FFFF));
		send_item(free_item(1'b0, 3'd7, 48'hFFFF_FFFF_FFFF));
		send_item(free_item(1'b1, 3'd7, 48'h0));

		// ascending table, no minimum, threshold 2
		settle();
		configure(TABLE_A_LOW, TABLE_A_HIGH, 16'd0, 7'd2);
		send_item(alloc_item(32'd1));
		send_item(free_item(1'b1, 3'd0, 48'h1234_5678_9ABC));
		send_item(alloc_item(32'd0));
		send_item(free_item(1'b1, 3'd3, 48'hA5A5_0000_0001));
		send_item(free_item(1'b1, 3'd3, 48'h5A5A_FFFF_FFFE));
		send_item(alloc_item(32'd100));
		send_item(alloc_item(32'd2048));
		send_item(alloc_item(32'd2048));
		send_item(alloc_item(32'd2049));
		send_item(free_item(1'b0, 3'd5, 48'h8000_0000_0000));

		// zero threshold: a lone entry flushes nothing
		settle();
		configure(TABLE_A_LOW, TABLE_A_HIGH, 16'd0, 7'd0);
		send_item(free_item(1'b1, 3'd4, 48'h0000_0000_4000));
		send_item(free_item(1'b1, 3'd4, 48'h0000_0000_8000));

		// table out of order: first fitting class wins
		settle();
		configure({16'd10, 16'd500, 16'd20, 16'd300}, {16'hFFFF, 16'd5, 16'd1000, 16'd50},
			MIN_REQ_RESET, FLUSH_THR_RESET);
		send_item(alloc_item(32'd15));
		send_item(alloc_item(32'd400));
		send_item(alloc_item(32'd2000));
		send_item(alloc_item(32'd70000));

		// random phases, each with its own register setting
		for (phase = 0; phase < 8; phase++) begin
			lo      = TABLE_A_LOW;
			hi      = TABLE_A_HIGH;
			minimum = MIN_REQ_RESET;
			thr     = FLUSH_THR_RESET;
			len     = 36;
			weight  = 45;
			case (phase)
				0: begin
					len    = 80;
					weight = 95;
				end
				1: begin
					minimum = 16'd0;
					thr     = 7'd2;
				end
				2: begin
					ascending_table(lo, hi);
					minimum = MIN_W'($urandom_range(0, 4096));
					thr     = 7'd5;
				end
				3: begin
					lo      = {$urandom, $urandom};
					hi      = {$urandom, $urandom};
					minimum = 16'hFFFF;
					thr     = 7'd127;
					len     = 80;
					weight  = 95;
				end
				4: begin
					lo      = {16'd4, 16'd2, 16'd1, 16'd0};
					hi      = {16'hFFFF, 16'h8000, 16'h1000, 16'h0100};
					minimum = 16'd0;
					thr     = 7'd1;
				end
				5: begin
					lo      = '1;
					hi      = '1;
					minimum = MIN_W'($urandom_range(0, 16'hFFFF));
					thr     = 7'd0;
				end
				6: begin
					ascending_table(lo, hi);
					thr = THR_W'($urandom_range(2, 64));
				end
				default: thr = 7'd8;
			endcase
			settle();
			configure(lo, hi, minimum, thr);
			hot = $urandom_range(0, CLASSES - 1);
			repeat (len) send_item(make_item(hot, weight));
		end

		settle();
		repeat (2 * MAX_RESULTS) @(posedge clk);
		if (board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
